/* hw/rtl/rssr_pkg.sv */
// Shared types and fixed constants for the RRIP signature/stream replacement block.
// No dependencies; every other file in hw/rtl imports this package.

package rssr_pkg;

    // Fixed widths of the request, response and configuration fields.
    localparam int SET_IN_W  = 11;
    localparam int MASK_W    = 16;
    localparam int WAY_IN_W  = 4;
    localparam int ADDR_W    = 48;
    localparam int DIFF_W    = ADDR_W + 1;
    localparam int PERIOD_W  = 17;
    localparam int DUEL_W    = 10;
    localparam int RRPV_W    = 2;
    localparam int CNT_W     = 2;
    localparam int SCORE_W   = 2;

    // Request kind codes.
    localparam logic KIND_VICTIM = 1'b0;

    // Saturation limits and reset values.
    localparam logic [RRPV_W-1:0]   RRPV_MAX           = 2'd3;
    localparam logic [CNT_W-1:0]    CNT_MAX            = 2'd3;
    localparam logic [CNT_W-1:0]    CNT_RESET          = 2'd1;
    localparam logic [SCORE_W-1:0]  SCORE_MAX          = 2'd3;
    localparam logic [DUEL_W-1:0]   DUEL_INIT          = 10'd512;
    localparam logic [DUEL_W-1:0]   DUEL_MAX           = 10'd1023;
    localparam logic [PERIOD_W-1:0] DECAY_PERIOD_RESET = 17'd100000;

    // Address strides that count as streaming (one or two cache lines).
    localparam int STRIDE_ONE = 64;
    localparam int STRIDE_TWO = 128;

    // Per-set stream detector entry.
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
        logic [SCORE_W-1:0] score;
    } stream_entry_t;

    // Status of the way scan unit toward the sequencer.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [RRPV_W-1:0] age;
    } scan_ctrl_t;

endpackage

/* hw/rtl/rssr_req_if.sv */
// Request channel of the replacement block: valid/ready plus the request fields.
// Depends on rssr_pkg for field widths.

interface rssr_req_if import rssr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [SET_IN_W-1:0]  set_index;
    logic [MASK_W-1:0]    valid_mask;
    logic [WAY_IN_W-1:0]  way_index;
    logic [ADDR_W-1:0]    byte_address;
    logic [ADDR_W-1:0]    program_counter;
    logic                 was_hit;

    modport source (
        output valid, kind, set_index, valid_mask, way_index,
               byte_address, program_counter, was_hit,
        input  ready
    );
    modport sink (
        input  valid, kind, set_index, valid_mask, way_index,
               byte_address, program_counter, was_hit,
        output ready
    );
endinterface

/* hw/rtl/rssr_rsp_if.sv */
// Response channel of the replacement block: valid/ready plus the victim way.
// Depends on rssr_pkg for the field width.

interface rssr_rsp_if import rssr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WAY_IN_W-1:0] victim_way;

    modport source (
        output valid, victim_way,
        input  ready
    );
    modport sink (
        input  valid, victim_way,
        output ready
    );
endinterface

/* hw/rtl/rssr_cfg_if.sv */
// Configuration write channel: valid/ready plus the decay period register value.
// Depends on rssr_pkg for the field width.

interface rssr_cfg_if import rssr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] decay_period;

    modport source (
        output valid, decay_period,
        input  ready
    );
    modport sink (
        input  valid, decay_period,
        output ready
    );
endinterface

/* hw/rtl/rssr_way_scan.sv */
// Way scan unit: walks one way per cycle to find the first invalid way, or the
// first way with the highest re-reference value and the aging step. Uses rssr_pkg.

module rssr_way_scan import rssr_pkg::*; #(
    parameter int NUM_WAYS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [NUM_WAYS-1:0][RRPV_W-1:0]  row,
    input  logic [NUM_WAYS-1:0]              mask,
    output scan_ctrl_t                       ctrl,
    output logic [$clog2(NUM_WAYS)-1:0]      victim
);

    localparam int WAY_W = $clog2(NUM_WAYS);

    logic [NUM_WAYS-1:0][RRPV_W-1:0] row_reg;
    logic [NUM_WAYS-1:0]             mask_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [WAY_W-1:0]                cnt_reg;
    logic [RRPV_W-1:0]               top_reg;
    logic [WAY_W-1:0]                top_idx_reg;
    logic                            inv_found_reg;
    logic [WAY_W-1:0]                inv_idx_reg;
    logic [RRPV_W-1:0]               cur_val;
    logic                            last_way;

    // The value under the shared compare this cycle.
    assign cur_val  = row_reg[cnt_reg];
    assign last_way = (cnt_reg == WAY_W'(NUM_WAYS - 1));

    // Capture the set row and valid bits when a scan starts.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg  <= row;
            mask_reg <= mask;
        end
    end

    // Scan sequencer: one way per cycle, strict compare keeps the first maximum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
            top_reg       <= '0;
            top_idx_reg   <= '0;
            inv_found_reg <= 1'b0;
            inv_idx_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg      <= 1'b1;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
            top_reg       <= '0;
            top_idx_reg   <= '0;
            inv_found_reg <= 1'b0;
            inv_idx_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (!inv_found_reg && !mask_reg[cnt_reg])
            begin
                inv_found_reg <= 1'b1;
                inv_idx_reg   <= cnt_reg;
            end
            if (cur_val > top_reg)
            begin
                top_reg     <= cur_val;
                top_idx_reg <= cnt_reg;
            end
            if (last_way)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // An invalid way wins and needs no aging; otherwise age the set to the maximum.
    assign ctrl.busy = busy_reg;
    assign ctrl.done = done_reg;
    assign ctrl.age  = inv_found_reg ? '0 : RRPV_MAX - top_reg;
    assign victim    = inv_found_reg ? inv_idx_reg : top_idx_reg;

    // The sequencer never restarts a scan that is still running.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("way scan restarted while busy");

    // Done follows directly on the last scan cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("scan done without a preceding scan");

    // A start always begins at way zero.
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == '0)
        else $error("scan did not begin at way zero");

endmodule

/* hw/rtl/rrip_signature_stream_replacement.sv */
// Top level of the RRIP replacement block with signature insertion, stride stream
// detection and set dueling. Depends on rssr_pkg, the three channel interfaces and rssr_way_scan.
//
//  Channel   Direction   Carries
//  -------   ---------   --------------------------------------------------------
//  req       in          kind, set_index, valid_mask, way_index, byte_address,
//                        program_counter, was_hit
//  rsp       out         victim_way (one per victim request, none for updates)
//  cfg       in          decay_period (always ready)
//
// A victim request is served by the way scan unit, which compares one way a cycle.
// When the decay period expires, an update request is followed by a read-modify-write
// sweep over the reuse counter memory.
// A set index at or above NUM_SETS is reduced by repeated subtraction of NUM_SETS.
// After reset a clearing pass over all set rows and reuse counters runs before req is ready.
// The response sits in an output register; a stalled response holds back only the next victim.

module rrip_signature_stream_replacement import rssr_pkg::*; #(
    parameter int NUM_SETS         = 2048,
    parameter int NUM_WAYS         = 16,
    parameter int SIG_WIDTH        = 6,
    parameter int LEADERS_PER_SIDE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    rssr_req_if.sink    req,
    rssr_rsp_if.source  rsp,
    rssr_cfg_if.sink    cfg
);

    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int WAY_W       = $clog2(NUM_WAYS);
    localparam int SIG_ENTRIES = 1 << SIG_WIDTH;
    localparam int SWEEP_DEPTH = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int SWEEP_W     = $clog2(SWEEP_DEPTH) + 1;

    localparam logic [RRPV_W-1:0] RRPV_NEAR  = 2'd0;
    localparam logic [RRPV_W-1:0] RRPV_INTER = 2'd2;

    localparam logic [DIFF_W-1:0] DIFF_POS_ONE = DIFF_W'(STRIDE_ONE);
    localparam logic [DIFF_W-1:0] DIFF_POS_TWO = DIFF_W'(STRIDE_TWO);
    localparam logic [DIFF_W-1:0] DIFF_NEG_ONE = ~DIFF_W'(STRIDE_ONE) + 1'b1;
    localparam logic [DIFF_W-1:0] DIFF_NEG_TWO = ~DIFF_W'(STRIDE_TWO) + 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_MOD,
        ST_VSTART,
        ST_VSCAN,
        ST_VDONE,
        ST_UDIFF,
        ST_UAPPLY,
        ST_DECAY
    } state_t;

    typedef logic [NUM_WAYS-1:0][RRPV_W-1:0] row_t;

    // Sequencer and registered outputs.
    state_t               state_reg, state_next;
    logic [SWEEP_W-1:0]   sweep_reg, sweep_next;
    logic [DUEL_W-1:0]    duel_reg, duel_next;
    logic [PERIOD_W-1:0]  decay_count_reg, decay_count_next;
    logic [PERIOD_W-1:0]  decay_period_reg, decay_period_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [WAY_IN_W-1:0]  victim_reg, victim_next;

    // Captured request fields.
    logic                 kind_reg;
    logic [SET_IN_W-1:0]  red_reg;
    logic [NUM_WAYS-1:0]  mask_reg;
    logic [WAY_IN_W-1:0]  way_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [SIG_WIDTH-1:0] sig_reg;
    logic                 hit_reg;
    logic [DIFF_W-1:0]    diff_reg;

    // Memories and their ports.
    row_t                 reref_mem [NUM_SETS];
    stream_entry_t        stream_mem [NUM_SETS];
    logic [CNT_W-1:0]     reuse_mem [SIG_ENTRIES];
    row_t                 reref_rdata_reg;
    stream_entry_t        stream_rdata_reg;
    logic [CNT_W-1:0]     reuse_rdata_reg;
    logic                 reref_we, stream_we, reuse_we;
    logic [SET_W-1:0]     reref_waddr, stream_waddr;
    logic [SIG_WIDTH-1:0] reuse_waddr, reuse_raddr;
    row_t                 reref_wdata;
    stream_entry_t        stream_wdata;
    logic [CNT_W-1:0]     reuse_wdata;

    // Datapath signals.
    logic                 req_fire;
    logic [NUM_WAYS-1:0]  mask_in;
    logic [SET_W-1:0]     set_idx;
    logic                 red_big;
    scan_ctrl_t           scan_ctrl;
    logic [WAY_W-1:0]     scan_way;
    row_t                 aged_row;
    row_t                 upd_row;
    logic                 stride_hit;
    logic [SCORE_W-1:0]   score_new;
    logic                 streaming;
    logic [CNT_W-1:0]     cnt_new;
    logic [CNT_W-1:0]     cnt_decayed;
    logic                 sig_leader;
    logic                 stream_leader;
    logic                 use_stream;
    logic                 way_ok;
    logic [RRPV_W-1:0]    new_rrpv;
    logic [DUEL_W-1:0]    duel_upd;
    logic [PERIOD_W-1:0]  period_eff;
    logic [PERIOD_W-1:0]  count_inc;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.victim_way = victim_reg;

    // Ways beyond the mask width count as valid.
    for (genvar w = 0; w < NUM_WAYS; w++)
    begin : g_mask
        if (w < MASK_W)
        begin : g_in
            assign mask_in[w] = req.valid_mask[w];
        end
        else
        begin : g_hi
            assign mask_in[w] = 1'b1;
        end
    end

    assign set_idx = SET_W'(red_reg);
    assign red_big = (32'(red_reg) >= NUM_SETS);

    // Way scan unit for victim selection.
    rssr_way_scan #(
        .NUM_WAYS (NUM_WAYS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == ST_VSTART),
        .row    (reref_rdata_reg),
        .mask   (mask_reg),
        .ctrl   (scan_ctrl),
        .victim (scan_way)
    );

    // Request capture, set index reduction and the address difference.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= req.kind;
            red_reg  <= req.set_index;
            mask_reg <= mask_in;
            way_reg  <= req.way_index;
            addr_reg <= req.byte_address;
            sig_reg  <= req.program_counter[SIG_WIDTH-1:0]
                      ^ req.program_counter[2*SIG_WIDTH-1:SIG_WIDTH]
                      ^ req.program_counter[3*SIG_WIDTH-1:2*SIG_WIDTH];
            hit_reg  <= req.was_hit;
        end
        else if (state_reg == ST_MOD && red_big)
        begin
            red_reg <= red_reg - SET_IN_W'(NUM_SETS);
        end
        if (state_reg == ST_UDIFF)
        begin
            diff_reg <= {1'b0, addr_reg} - {1'b0, stream_rdata_reg.addr};
        end
    end

    // Set memories: one read at the current set, one write port.
    always_ff @(posedge clk)
    begin
        if (reref_we)
        begin
            reref_mem[reref_waddr] <= reref_wdata;
        end
        if (stream_we)
        begin
            stream_mem[stream_waddr] <= stream_wdata;
        end
        reref_rdata_reg  <= reref_mem[set_idx];
        stream_rdata_reg <= stream_mem[set_idx];
    end

    // Reuse counter memory: the decay sweep reads one entry while writing back the previous.
    assign reuse_raddr = (state_reg == ST_DECAY) ? sweep_reg[SIG_WIDTH-1:0] : sig_reg;

    always_ff @(posedge clk)
    begin
        if (reuse_we)
        begin
            reuse_mem[reuse_waddr] <= reuse_wdata;
        end
        reuse_rdata_reg <= reuse_mem[reuse_raddr];
    end

    // Aging of the victim set by the step the scan unit found.
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged_row[w] = reref_rdata_reg[w] + scan_ctrl.age;
        end
    end

    // Update training: stream score, reuse counter, leader role and insertion value.
    always_comb
    begin
        stride_hit = (diff_reg == DIFF_POS_ONE) || (diff_reg == DIFF_POS_TWO)
                  || (diff_reg == DIFF_NEG_ONE) || (diff_reg == DIFF_NEG_TWO);
        if (!stream_rdata_reg.valid)
        begin
            score_new = '0;
        end
        else if (stride_hit)
        begin
            score_new = (stream_rdata_reg.score == SCORE_MAX) ? SCORE_MAX
                                                              : stream_rdata_reg.score + 1'b1;
        end
        else
        begin
            score_new = (stream_rdata_reg.score == '0) ? '0 : stream_rdata_reg.score - 1'b1;
        end
        streaming = score_new[SCORE_W-1];

        if (hit_reg)
        begin
            cnt_new = (reuse_rdata_reg == CNT_MAX) ? CNT_MAX : reuse_rdata_reg + 1'b1;
        end
        else
        begin
            cnt_new = (reuse_rdata_reg == '0) ? '0 : reuse_rdata_reg - 1'b1;
        end
        cnt_decayed = (reuse_rdata_reg == '0) ? '0 : reuse_rdata_reg - 1'b1;

        sig_leader    = (32'(set_idx) >= NUM_SETS - LEADERS_PER_SIDE);
        stream_leader = !sig_leader && (32'(set_idx) < LEADERS_PER_SIDE);
        if (stream_leader)
        begin
            use_stream = 1'b1;
        end
        else if (sig_leader)
        begin
            use_stream = 1'b0;
        end
        else
        begin
            use_stream = (duel_reg >= DUEL_INIT);
        end

        duel_upd = duel_reg;
        if (use_stream && streaming)
        begin
            new_rrpv = RRPV_MAX;
            if (stream_leader)
            begin
                if (hit_reg && duel_reg != DUEL_MAX)
                begin
                    duel_upd = duel_reg + 1'b1;
                end
                else if (!hit_reg && duel_reg != '0)
                begin
                    duel_upd = duel_reg - 1'b1;
                end
            end
        end
        else
        begin
            new_rrpv = cnt_new[CNT_W-1] ? RRPV_NEAR : RRPV_INTER;
            if (sig_leader)
            begin
                if (hit_reg && duel_reg != '0)
                begin
                    duel_upd = duel_reg - 1'b1;
                end
                else if (!hit_reg && duel_reg != DUEL_MAX)
                begin
                    duel_upd = duel_reg + 1'b1;
                end
            end
        end

        // A way index past the associativity still trains but writes no value.
        way_ok  = (32'(way_reg) < NUM_WAYS);
        upd_row = reref_rdata_reg;
        if (way_ok)
        begin
            upd_row[WAY_W'(way_reg)] = new_rrpv;
        end

        period_eff = (decay_period_reg == '0) ? PERIOD_W'(1) : decay_period_reg;
        count_inc  = decay_count_reg + 1'b1;
    end

    // Sequencer next state and memory write control.
    always_comb
    begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        duel_next         = duel_reg;
        decay_count_next  = decay_count_reg;
        decay_period_next = decay_period_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        victim_next       = victim_reg;

        reref_we     = 1'b0;
        reref_waddr  = set_idx;
        reref_wdata  = upd_row;
        stream_we    = 1'b0;
        stream_waddr = set_idx;
        stream_wdata = '{valid: 1'b1, addr: addr_reg, score: score_new};
        reuse_we     = 1'b0;
        reuse_waddr  = sig_reg;
        reuse_wdata  = cnt_new;

        if (cfg.valid)
        begin
            decay_period_next = cfg.decay_period;
        end

        case (state_reg)
            ST_INIT:
            begin
                // Clearing pass over all set rows and reuse counters.
                if (32'(sweep_reg) < NUM_SETS)
                begin
                    reref_we     = 1'b1;
                    reref_waddr  = sweep_reg[SET_W-1:0];
                    reref_wdata  = {NUM_WAYS{RRPV_MAX}};
                    stream_we    = 1'b1;
                    stream_waddr = sweep_reg[SET_W-1:0];
                    stream_wdata = '0;
                end
                if (32'(sweep_reg) < SIG_ENTRIES)
                begin
                    reuse_we    = 1'b1;
                    reuse_waddr = sweep_reg[SIG_WIDTH-1:0];
                    reuse_wdata = CNT_RESET;
                end
                if (32'(sweep_reg) == SWEEP_DEPTH - 1)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                // The set memories read the final index on the last cycle here.
                if (!red_big)
                begin
                    state_next = (kind_reg == KIND_VICTIM) ? ST_VSTART : ST_UDIFF;
                end
            end
            ST_VSTART:
            begin
                state_next = ST_VSCAN;
            end
            ST_VSCAN:
            begin
                if (scan_ctrl.done)
                begin
                    state_next = ST_VDONE;
                end
            end
            ST_VDONE:
            begin
                // Write back the aged set and load the response once the register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    reref_we       = 1'b1;
                    reref_wdata    = aged_row;
                    rsp_valid_next = 1'b1;
                    victim_next    = WAY_IN_W'(scan_way);
                    state_next     = ST_IDLE;
                end
            end
            ST_UDIFF:
            begin
                state_next = ST_UAPPLY;
            end
            ST_UAPPLY:
            begin
                reref_we  = 1'b1;
                stream_we = 1'b1;
                reuse_we  = 1'b1;
                duel_next = duel_upd;
                if (count_inc >= period_eff)
                begin
                    decay_count_next = '0;
                    sweep_next       = '0;
                    state_next       = ST_DECAY;
                end
                else
                begin
                    decay_count_next = count_inc;
                    state_next       = ST_IDLE;
                end
            end
            ST_DECAY:
            begin
                // Entry sweep_reg is being read; entry sweep_reg - 1 is written back decremented.
                if (sweep_reg != '0)
                begin
                    reuse_we    = 1'b1;
                    reuse_waddr = SIG_WIDTH'(sweep_reg - 1'b1);
                    reuse_wdata = cnt_decayed;
                end
                if (32'(sweep_reg) == SIG_ENTRIES)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state, policy registers and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            sweep_reg        <= '0;
            duel_reg         <= DUEL_INIT;
            decay_count_reg  <= '0;
            decay_period_reg <= DECAY_PERIOD_RESET;
            rsp_valid_reg    <= 1'b0;
            victim_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            duel_reg         <= duel_next;
            decay_count_reg  <= decay_count_next;
            decay_period_reg <= decay_period_next;
            rsp_valid_reg    <= rsp_valid_next;
            victim_reg       <= victim_next;
        end
    end

    // An accepted request always enters set index reduction first.
    a_accept_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == ST_MOD)
        else $error("accepted request did not start processing");

    // The duel selector moves only when an update is applied.
    a_duel_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(duel_reg) |-> $past(state_reg == ST_UAPPLY))
        else $error("duel selector changed outside an update");

    // A new response comes only from the end of a victim search.
    a_rsp_from_victim: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_VDONE))
        else $error("response raised outside victim completion");

    // The decay sweep never runs past the last reuse counter.
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECAY |-> 32'(sweep_reg) <= SIG_ENTRIES)
        else $error("decay sweep overran the counter memory");

endmodule
